>>> rtl/ppes_pkg.sv
// shared constants for the predator-prey euler step unit
`timescale 1ns / 1ps
package ppes_pkg;

  localparam int unsigned PopW       = 32;  // q16.16 population and q8.24 rate width
  localparam int unsigned HalfW      = 16;  // fraction bits of a q16.16 value
  localparam int unsigned DtW        = 24;
  localparam int unsigned CritW      = 17;
  localparam int unsigned FracW      = 24;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 24;

  // quotient bits resolved per divider stage
  localparam int unsigned DivStepsPerStage = 4;

  localparam logic [DtW-1:0]     DtReset   = 24'd321746;
  localparam logic [CritW-1:0]   CritReset = 17'd13107;
  localparam logic [PopW-1:0]    OneQ16    = 32'h0001_0000;
  localparam logic [FracW-1:0]   FracMax   = 24'hFF_FFFF;

  localparam logic [CfgIdxW-1:0] CfgIdxDt   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxCrit = 1'b1;

endpackage

>>> rtl/ppes_div.sv
// pipelined restoring divider, (pop << 16) / den, one item per cycle while en_i is high
`timescale 1ns / 1ps
module ppes_div import ppes_pkg::*; #(
  parameter int unsigned Lanes         = 1,
  parameter int unsigned PayW          = 1,
  parameter int unsigned StepsPerStage = DivStepsPerStage
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [PopW-1:0] num_i [Lanes],
  input  logic [PopW-1:0] den_i [Lanes],
  input  logic [PayW-1:0] pay_i,
  output logic            valid_o,
  output logic [PopW-1:0] quo_o [Lanes],
  output logic [PayW-1:0] pay_o
);

  localparam int unsigned NumStg = PopW / StepsPerStage;

  typedef struct packed {
    logic [PopW-1:0] rem;
    logic [PopW-1:0] lq;   // dividend bits still to shift in, quotient bits shifted in
    logic [PopW-1:0] den;
  } lane_t;

  lane_t           src   [NumStg][Lanes];
  lane_t           st_d  [NumStg][Lanes];
  lane_t           st_q  [NumStg][Lanes];
  logic [PayW-1:0] pay_q [NumStg];
  logic [NumStg-1:0] vld_q;

  for (genvar s = 0; s < NumStg; s++) begin : g_stg
    if (s == 0) begin : g_first
      for (genvar l = 0; l < Lanes; l++) begin : g_in
        assign src[0][l].rem = {{(PopW-HalfW){1'b0}}, num_i[l][PopW-1:HalfW]};
        assign src[0][l].lq  = {num_i[l][HalfW-1:0], {HalfW{1'b0}}};
        assign src[0][l].den = den_i[l];
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[0] <= 1'b0;
        end else if (en_i) begin
          vld_q[0] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pay_q[0] <= pay_i;
        end
      end
    end else begin : g_rest
      for (genvar l = 0; l < Lanes; l++) begin : g_in
        assign src[s][l] = st_q[s-1][l];
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[s] <= 1'b0;
        end else if (en_i) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pay_q[s] <= pay_q[s-1];
        end
      end
    end

    always_comb begin
      lane_t         cur;
      logic [PopW:0] t;
      for (int l = 0; l < Lanes; l++) begin
        cur = src[s][l];
        for (int j = 0; j < StepsPerStage; j++) begin
          t = {cur.rem, cur.lq[PopW-1]};
          if (t >= {1'b0, cur.den}) begin
            cur.rem = PopW'(t - {1'b0, cur.den});
            cur.lq  = {cur.lq[PopW-2:0], 1'b1};
          end else begin
            cur.rem = t[PopW-1:0];
            cur.lq  = {cur.lq[PopW-2:0], 1'b0};
          end
        end
        st_d[s][l] = cur;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_out
    assign quo_o[l] = st_q[NumStg-1][l].lq;
  end
  assign pay_o   = pay_q[NumStg-1];
  assign valid_o = vld_q[NumStg-1];

endmodule

>>> rtl/predator_prey_euler_step_unit.sv
// top level: one lotka-volterra euler step with logistic prey growth per transfer
`timescale 1ns / 1ps
// usage
//   s_axis_*: one predator-prey pair per transfer, ten 32-bit fields in tdata
//   m_axis_*: one result per pair, new populations, fractions and flags
//   cfg_*   : write dt_years (index 0) and the critical threshold (index 1) while idle
// pipeline
//   an input pair passes stages 1 and 2, the pipelined n / k divider, stages
//   3 to 8, the pipelined divider of new population over reference and the
//   output register; by default 4 quotient bits are resolved per divider stage
// throughput
//   one pair per cycle while not stalled, every stage is registered and moves on the same enable
// reset
//   all valid bits clear, dt_years returns to one week, the critical threshold to 0.2
// stall
//   while the result waits on m_axis_tready_i the whole pipe holds and
//   s_axis_tready_o drops; nothing is lost or repeated, empty slots hold as well
module predator_prey_euler_step_unit import ppes_pkg::*; #(
  parameter int unsigned StepsPerStage = DivStepsPerStage
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // prey_pop, pred_pop, prey_birth_rate, prey_predation_rate, prey_capacity,
  // pred_death_rate, pred_attack_rate, pred_conversion, prey_initial, pred_initial
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [319:0]        s_axis_tdata_i,
  // new_prey_pop, new_pred_pop, prey_fraction, pred_fraction, prey_critical,
  // pred_critical, saturated, 5 zero bits
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [119:0]        m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned ProdW = 2 * PopW;  // 64
  localparam int unsigned WideW = 3 * PopW;  // 96
  localparam int unsigned MagW  = WideW + 1; // 97
  localparam int unsigned PartW = PopW + DtW;

  // ---------------------------------------------------------------- config
  logic [DtW-1:0]   dt_q;
  logic [CritW-1:0] crit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q   <= DtReset;
      crit_q <= CritReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgIdxDt:   dt_q   <= cfg_wdata_i[DtW-1:0];
        CfgIdxCrit: crit_q <= cfg_wdata_i[CritW-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves when the output slot is free or taken
  logic adv;
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // input fields
  logic [PopW-1:0] in_n, in_p, in_r, in_a, in_k, in_d, in_b, in_c, in_n0, in_p0;
  assign in_n  = s_axis_tdata_i[31:0];
  assign in_p  = s_axis_tdata_i[63:32];
  assign in_r  = s_axis_tdata_i[95:64];
  assign in_a  = s_axis_tdata_i[127:96];
  assign in_k  = s_axis_tdata_i[159:128];
  assign in_d  = s_axis_tdata_i[191:160];
  assign in_b  = s_axis_tdata_i[223:192];
  assign in_c  = s_axis_tdata_i[255:224];
  assign in_n0 = s_axis_tdata_i[287:256];
  assign in_p0 = s_axis_tdata_i[319:288];

  // ---------------------------------------------------------------- stage 1
  // first products, floors on capacity and references
  typedef struct packed {
    logic [ProdW-1:0] rn, an, bc, dp;
    logic [PopW-1:0]  n, p, kk, n0, p0;
  } s1_t;
  s1_t  s1_d, s1_q;
  logic v1_q;

  always_comb begin
    s1_d.rn = ProdW'(in_r) * ProdW'(in_n);
    s1_d.an = ProdW'(in_a) * ProdW'(in_n);
    s1_d.bc = ProdW'(in_b) * ProdW'(in_c);
    s1_d.dp = ProdW'(in_d) * ProdW'(in_p);
    s1_d.n  = in_n;
    s1_d.p  = in_p;
    s1_d.kk = (in_k  < OneQ16) ? OneQ16 : in_k;
    s1_d.n0 = (in_n0 < OneQ16) ? OneQ16 : in_n0;
    s1_d.p0 = (in_p0 < OneQ16) ? OneQ16 : in_p0;
  end

  // ---------------------------------------------------------------- stage 2
  // predation partial products, c*b truncated to q8.24 and saturated, times n
  typedef struct packed {
    logic [ProdW-1:0] rn, loss_lo, loss_hi, bcn, dp;
    logic [PopW-1:0]  n, p, n0, p0;
  } s2_t;
  s2_t             s2_d, s2_q;
  logic            v2_q;
  logic [PopW-1:0] s2_kk_q;
  logic [PopW-1:0] bc_sat;

  always_comb begin
    bc_sat     = (|s1_q.bc[ProdW-1:PopW+DtW]) ? '1 : s1_q.bc[PopW+DtW-1:DtW];
    s2_d.rn      = s1_q.rn;
    s2_d.loss_lo = ProdW'(s1_q.an[PopW-1:0])     * ProdW'(s1_q.p);
    s2_d.loss_hi = ProdW'(s1_q.an[ProdW-1:PopW]) * ProdW'(s1_q.p);
    s2_d.bcn     = ProdW'(bc_sat) * ProdW'(s1_q.n);
    s2_d.dp      = s1_q.dp;
    s2_d.n       = s1_q.n;
    s2_d.p       = s1_q.p;
    s2_d.n0      = s1_q.n0;
    s2_d.p0      = s1_q.p0;
  end

  // ---------------------------------------------------------------- n / k
  logic            qa_vld;
  logic [PopW-1:0] qa_num [1];
  logic [PopW-1:0] qa_den [1];
  logic [PopW-1:0] qa_quo [1];
  s2_t             qa_pay;

  assign qa_num[0] = s2_q.n;
  assign qa_den[0] = s2_kk_q;

  ppes_div #(
    .Lanes         (1),
    .PayW          ($bits(s2_t)),
    .StepsPerStage (StepsPerStage)
  ) u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .num_i   (qa_num),
    .den_i   (qa_den),
    .pay_i   (s2_q),
    .valid_o (qa_vld),
    .quo_o   (qa_quo),
    .pay_o   (qa_pay)
  );

  // ---------------------------------------------------------------- stage 3
  // 1 - n/k as sign and magnitude, growth and conversion partial products
  typedef struct packed {
    logic             om_neg;
    logic [ProdW-1:0] grow_lo, grow_hi, pp_lo, pp_hi;
    logic [WideW-1:0] loss;
    logic [ProdW-1:0] dp;
    logic [PopW-1:0]  n, p, n0, p0;
  } s3_t;
  s3_t             s3_d, s3_q;
  logic            v3_q;
  logic [PopW-1:0] om;

  always_comb begin
    s3_d.om_neg  = qa_quo[0] > OneQ16;
    om           = s3_d.om_neg ? (qa_quo[0] - OneQ16) : (OneQ16 - qa_quo[0]);
    s3_d.grow_lo = ProdW'(qa_pay.rn[PopW-1:0])      * ProdW'(om);
    s3_d.grow_hi = ProdW'(qa_pay.rn[ProdW-1:PopW])  * ProdW'(om);
    s3_d.pp_lo   = ProdW'(qa_pay.bcn[PopW-1:0])     * ProdW'(qa_pay.p);
    s3_d.pp_hi   = ProdW'(qa_pay.bcn[ProdW-1:PopW]) * ProdW'(qa_pay.p);
    s3_d.loss    = {{PopW{1'b0}}, qa_pay.loss_lo} + {qa_pay.loss_hi, {PopW{1'b0}}};
    s3_d.dp      = qa_pay.dp;
    s3_d.n       = qa_pay.n;
    s3_d.p       = qa_pay.p;
    s3_d.n0      = qa_pay.n0;
    s3_d.p0      = qa_pay.p0;
  end

  // ---------------------------------------------------------------- stage 4
  // assemble growth and conversion terms at scale 2^-56
  typedef struct packed {
    logic             om_neg;
    logic [WideW-1:0] grow, loss, pp, dpk;
    logic [PopW-1:0]  n, p, n0, p0;
  } s4_t;
  s4_t  s4_d, s4_q;
  logic v4_q;

  always_comb begin
    s4_d.om_neg = s3_q.om_neg;
    s4_d.grow   = {{PopW{1'b0}}, s3_q.grow_lo} + {s3_q.grow_hi, {PopW{1'b0}}};
    s4_d.pp     = {{PopW{1'b0}}, s3_q.pp_lo} + {s3_q.pp_hi, {PopW{1'b0}}};
    s4_d.loss   = s3_q.loss;
    // d*p scaled by one in q16.16
    s4_d.dpk    = {{HalfW{1'b0}}, s3_q.dp, {HalfW{1'b0}}};
    s4_d.n      = s3_q.n;
    s4_d.p      = s3_q.p;
    s4_d.n0     = s3_q.n0;
    s4_d.p0     = s3_q.p0;
  end

  // ---------------------------------------------------------------- stage 5
  // rates of change as sign and magnitude
  typedef struct packed {
    logic            dn_neg, dp_neg;
    logic [MagW-1:0] dn_mag, dp_mag;
    logic [PopW-1:0] n, p, n0, p0;
  } s5_t;
  s5_t             s5_d, s5_q;
  logic            v5_q;
  logic [MagW-1:0] dn_diff, dp_diff;

  always_comb begin
    dn_diff = {1'b0, s4_q.grow} - {1'b0, s4_q.loss};
    dp_diff = {1'b0, s4_q.pp}   - {1'b0, s4_q.dpk};
    if (s4_q.om_neg) begin
      // crowded prey: both terms pull down
      s5_d.dn_neg = 1'b1;
      s5_d.dn_mag = {1'b0, s4_q.grow} + {1'b0, s4_q.loss};
    end else begin
      s5_d.dn_neg = dn_diff[MagW-1];
      s5_d.dn_mag = dn_diff[MagW-1] ? (~dn_diff + 1'b1) : dn_diff;
    end
    s5_d.dp_neg = dp_diff[MagW-1];
    s5_d.dp_mag = dp_diff[MagW-1] ? (~dp_diff + 1'b1) : dp_diff;
    s5_d.n      = s4_q.n;
    s5_d.p      = s4_q.p;
    s5_d.n0     = s4_q.n0;
    s5_d.p0     = s4_q.p0;
  end

  // ---------------------------------------------------------------- stage 6
  // magnitude times dt, four 32 x 24 partial products per population
  typedef struct packed {
    logic                  dn_neg, dp_neg;
    logic [3:0][PartW-1:0] dn_pp, dp_pp;
    logic [PopW-1:0]       n, p, n0, p0;
  } s6_t;
  s6_t                  s6_d, s6_q;
  logic                 v6_q;
  logic [4*PopW-1:0]    dn_ext, dp_ext;

  always_comb begin
    dn_ext = (4*PopW)'(s5_q.dn_mag);
    dp_ext = (4*PopW)'(s5_q.dp_mag);
    for (int i = 0; i < 4; i++) begin
      s6_d.dn_pp[i] = PartW'(dn_ext[i*PopW +: PopW]) * PartW'(dt_q);
      s6_d.dp_pp[i] = PartW'(dp_ext[i*PopW +: PopW]) * PartW'(dt_q);
    end
    s6_d.dn_neg = s5_q.dn_neg;
    s6_d.dp_neg = s5_q.dp_neg;
    s6_d.n      = s5_q.n;
    s6_d.p      = s5_q.p;
    s6_d.n0     = s5_q.n0;
    s6_d.p0     = s5_q.p0;
  end

  // ---------------------------------------------------------------- stage 7
  // sum partials, keep the integer part over 2^64 and a sticky bit below it
  typedef struct packed {
    logic             dn_neg, dp_neg, dn_lo, dp_lo;
    logic [ProdW-1:0] dn_hi, dp_hi;
    logic [PopW-1:0]  n, p, n0, p0;
  } s7_t;
  s7_t               s7_d, s7_q;
  logic              v7_q;
  logic [4*PopW-1:0] dn_s, dp_s;

  always_comb begin
    dn_s = '0;
    dp_s = '0;
    for (int i = 0; i < 4; i++) begin
      dn_s = dn_s + ((4*PopW)'(s6_q.dn_pp[i]) << (i*PopW));
      dp_s = dp_s + ((4*PopW)'(s6_q.dp_pp[i]) << (i*PopW));
    end
    s7_d.dn_hi  = dn_s[4*PopW-1:ProdW];
    s7_d.dp_hi  = dp_s[4*PopW-1:ProdW];
    s7_d.dn_lo  = |dn_s[ProdW-1:0];
    s7_d.dp_lo  = |dp_s[ProdW-1:0];
    s7_d.dn_neg = s6_q.dn_neg;
    s7_d.dp_neg = s6_q.dp_neg;
    s7_d.n      = s6_q.n;
    s7_d.p      = s6_q.p;
    s7_d.n0     = s6_q.n0;
    s7_d.p0     = s6_q.p0;
  end

  // ---------------------------------------------------------------- stage 8
  // floored step added to the old population, clamped to [0, max]
  function automatic logic [PopW-1:0] step_pop(input logic [PopW-1:0]  pop,
                                               input logic             neg,
                                               input logic [ProdW-1:0] hi,
                                               input logic             lo);
    logic [ProdW:0] mag;
    logic [ProdW:0] sum;
    logic [PopW-1:0] res;
    // negative change rounds away from zero so the step is floored
    mag = {1'b0, hi} + (ProdW+1)'(neg & lo);
    sum = (ProdW+1)'(pop) + {1'b0, hi};
    if (neg) begin
      res = (mag > (ProdW+1)'(pop)) ? '0 : PopW'((ProdW+1)'(pop) - mag);
    end else begin
      res = (sum > (ProdW+1)'({PopW{1'b1}})) ? '1 : sum[PopW-1:0];
    end
    return res;
  endfunction

  typedef struct packed {
    logic            sat;
    logic [PopW-1:0] np, nn;
  } s8_t;
  s8_t             s8_d, s8_q;
  logic            v8_q;
  logic [PopW-1:0] s8_n0_q, s8_p0_q;

  always_comb begin
    s8_d.nn  = step_pop(s7_q.n, s7_q.dn_neg, s7_q.dn_hi, s7_q.dn_lo);
    s8_d.np  = step_pop(s7_q.p, s7_q.dp_neg, s7_q.dp_hi, s7_q.dp_lo);
    s8_d.sat = (&s8_d.nn) || (&s8_d.np);
  end

  // ---------------------------------------------------------------- fractions
  logic            qb_vld;
  logic [PopW-1:0] qb_num [2];
  logic [PopW-1:0] qb_den [2];
  logic [PopW-1:0] qb_quo [2];
  s8_t             qb_pay;

  assign qb_num[0] = s8_q.nn;
  assign qb_num[1] = s8_q.np;
  assign qb_den[0] = s8_n0_q;
  assign qb_den[1] = s8_p0_q;

  ppes_div #(
    .Lanes         (2),
    .PayW          ($bits(s8_t)),
    .StepsPerStage (StepsPerStage)
  ) u_div_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v8_q),
    .num_i   (qb_num),
    .den_i   (qb_den),
    .pay_i   (s8_q),
    .valid_o (qb_vld),
    .quo_o   (qb_quo),
    .pay_o   (qb_pay)
  );

  // ---------------------------------------------------------------- output register
  typedef struct packed {
    logic             sat, pred_crit, prey_crit;
    logic [FracW-1:0] pred_frac, prey_frac;
    logic [PopW-1:0]  np, nn;
  } out_t;
  out_t out_d, out_q;
  logic out_vld_q;
  logic fn_sat, fp_sat;

  always_comb begin
    fn_sat          = qb_quo[0] >= PopW'(FracMax);
    fp_sat          = qb_quo[1] >= PopW'(FracMax);
    out_d.nn        = qb_pay.nn;
    out_d.np        = qb_pay.np;
    out_d.prey_frac = fn_sat ? FracMax : qb_quo[0][FracW-1:0];
    out_d.pred_frac = fp_sat ? FracMax : qb_quo[1][FracW-1:0];
    out_d.prey_crit = FracW'(crit_q) > out_d.prey_frac;
    out_d.pred_crit = FracW'(crit_q) > out_d.pred_frac;
    out_d.sat       = qb_pay.sat || fn_sat || fp_sat;
  end

  // ---------------------------------------------------------------- pipe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      v7_q      <= 1'b0;
      v8_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= s_axis_tvalid_i;
      v2_q      <= v1_q;
      v3_q      <= qa_vld;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      v7_q      <= v6_q;
      v8_q      <= v7_q;
      out_vld_q <= qb_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      s2_kk_q <= s1_q.kk;
      s3_q    <= s3_d;
      s4_q    <= s4_d;
      s5_q    <= s5_d;
      s6_q    <= s6_d;
      s7_q    <= s7_d;
      s8_q    <= s8_d;
      s8_n0_q <= s7_q.n0;
      s8_p0_q <= s7_q.p0;
      out_q   <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'b0, out_q.sat, out_q.pred_crit, out_q.prey_crit,
                            out_q.pred_frac, out_q.prey_frac, out_q.np, out_q.nn};

  // ---------------------------------------------------------------- assertions
  // an accepted pair occupies the first stage on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v1_q)
    else $error("accepted transfer did not enter the pipe");

  // a stalled result freezes stage 8, ahead of the fraction divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> ($stable(v8_q) && $stable(s8_q)))
    else $error("pipe moved during output stall");

  // saturated flag agrees with the delivered values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_q.sat == ((&out_q.nn) || (&out_q.np) ||
                                       (out_q.prey_frac == FracMax) ||
                                       (out_q.pred_frac == FracMax))))
    else $error("saturated flag inconsistent with result");

  // critical flags agree with the threshold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((out_q.prey_crit == (FracW'(crit_q) > out_q.prey_frac)) &&
                         (out_q.pred_crit == (FracW'(crit_q) > out_q.pred_frac))))
    else $error("critical flag inconsistent with fraction");

endmodule

>>> verif/testbench.sv
// self-checking testbench for the predator-prey euler step unit
`timescale 1ns / 1ps
module testbench;
  import ppes_pkg::*;

  // one predator-prey pair as it travels on the slave stream
  typedef struct packed {
    logic [31:0] pred_initial;
    logic [31:0] prey_initial;
    logic [31:0] conversion;
    logic [31:0] attack;
    logic [31:0] death;
    logic [31:0] capacity;
    logic [31:0] predation;
    logic [31:0] birth;
    logic [31:0] pred;
    logic [31:0] prey;
  } pair_t;

  // one step result, fields in master tdata order from the top bit down
  typedef struct packed {
    logic        sat;
    logic        pred_crit;
    logic        prey_crit;
    logic [23:0] pred_frac;
    logic [23:0] prey_frac;
    logic [31:0] new_pred;
    logic [31:0] new_prey;
  } step_t;

  localparam int unsigned DrainCycles = 40;     // idle time after the last result, longer than the pipe latency
  localparam int unsigned CycleLimit  = 900000;
  localparam logic [31:0] PopMax      = 32'hFFFF_FFFF;

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o;
  logic [319:0] s_axis_tdata_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [119:0] m_axis_tdata_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  predator_prey_euler_step_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  // our copy of the two registers
  logic [DtW-1:0]   step_dt;
  logic [CritW-1:0] crit_level;

  pair_t pending_pairs[$];
  step_t expected_steps[$];
  pair_t pair_on_bus;
  int unsigned errors = 0, pairs_sent = 0, steps_seen = 0, crit_hits = 0, sat_hits = 0;
  int unsigned cycles = 0;
  bit no_idle = 0;  // phase without any gaps or stalls

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  // population plus floor(rate * dt / 2^64), clamped to the 32-bit range
  function automatic logic [31:0] advance_pop(logic [31:0] pop, logic signed [135:0] rate,
                                              ref logic sat);
    logic signed [167:0] prod, v;
    prod = 168'(rate) * $signed({144'd0, step_dt});
    v = $signed({136'd0, pop}) + (prod >>> 64);
    if (v < 0) v = 0;
    if (v > $signed({136'd0, PopMax})) v = $signed({136'd0, PopMax});
    if (v[31:0] == PopMax) sat = 1;
    return v[31:0];
  endfunction

  // q8.16 ratio against a reference floored at one, saturating
  function automatic logic [23:0] ratio_of(logic [31:0] pop, logic [31:0] ref_pop,
                                           ref logic sat);
    logic [47:0] base, f;
    base = (ref_pop < OneQ16) ? 48'(OneQ16) : 48'(ref_pop);
    f = {pop, 16'd0} / base;
    if (f >= 48'(FracMax)) begin
      f = 48'(FracMax);
      sat = 1;
    end
    return f[23:0];
  endfunction

  function automatic step_t euler_step(pair_t it);
    logic [31:0] cap;
    logic [47:0] q;
    logic [31:0] om;
    logic om_neg;
    logic [63:0] bc;
    logic [127:0] grow, loss, gain, decay;
    logic signed [135:0] dn, dp;
    logic sat;
    step_t r;
    sat = 0;
    cap = (it.capacity < OneQ16) ? OneQ16 : it.capacity;
    q = {it.prey, 16'd0} / {16'd0, cap};
    // prey above capacity turns logistic growth into decline
    om_neg = q > 48'(OneQ16);
    om = om_neg ? 32'(q - 48'(OneQ16)) : 32'(48'(OneQ16) - q);
    grow = 128'(it.birth) * 128'(it.prey) * 128'(om);
    loss = 128'(it.predation) * 128'(it.prey) * 128'(it.pred);
    bc = (64'(it.attack) * 64'(it.conversion)) >> 24;
    if (bc > 64'(PopMax)) bc = 64'(PopMax);
    gain = 128'(bc) * 128'(it.prey) * 128'(it.pred);
    decay = (128'(it.death) * 128'(it.pred)) << 16;
    if (om_neg) dn = -$signed({8'd0, grow + loss});
    else        dn = $signed({8'd0, grow}) - $signed({8'd0, loss});
    dp = $signed({8'd0, gain}) - $signed({8'd0, decay});
    r.new_prey  = advance_pop(it.prey, dn, sat);
    r.new_pred  = advance_pop(it.pred, dp, sat);
    r.prey_frac = ratio_of(r.new_prey, it.prey_initial, sat);
    r.pred_frac = ratio_of(r.new_pred, it.pred_initial, sat);
    r.prey_crit = 25'(r.prey_frac) < 25'(crit_level);
    r.pred_crit = 25'(r.pred_frac) < 25'(crit_level);
    r.sat = sat;
    return r;
  endfunction

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %h expected %h", steps_seen, what, got, want);
  endtask

  // driver: one pair per transfer, random gap after each
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 0;
      s_axis_tdata_i <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_steps.push_back(euler_step(pair_on_bus));
        pairs_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid_i <= 0;
        end else if (pending_pairs.size() > 0) begin
          pair_on_bus = pending_pairs.pop_front();
          s_axis_tdata_i <= pair_on_bus;
          s_axis_tvalid_i <= 1;
          send_gap = draw_wait();
        end else begin
          s_axis_tvalid_i <= 0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  int unsigned stall = 0;
  always @(posedge clk_i) begin
    step_t got, want;
    if (!rst_ni) begin
      m_axis_tready_i <= 0;
    end else begin
      cycles++;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[114:0];
        if (expected_steps.size() == 0) begin
          errors++;
          $display("unexpected result transfer %h", m_axis_tdata_o);
        end else begin
          want = expected_steps.pop_front();
          if (got.new_prey != want.new_prey)
            report("new_prey_pop", 48'(got.new_prey), 48'(want.new_prey));
          if (got.new_pred != want.new_pred)
            report("new_pred_pop", 48'(got.new_pred), 48'(want.new_pred));
          if (got.prey_frac != want.prey_frac)
            report("prey_fraction", 48'(got.prey_frac), 48'(want.prey_frac));
          if (got.pred_frac != want.pred_frac)
            report("pred_fraction", 48'(got.pred_frac), 48'(want.pred_frac));
          if (got.prey_crit != want.prey_crit)
            report("prey_critical", 48'(got.prey_crit), 48'(want.prey_crit));
          if (got.pred_crit != want.pred_crit)
            report("pred_critical", 48'(got.pred_crit), 48'(want.pred_crit));
          if (got.sat != want.sat) report("saturated", 48'(got.sat), 48'(want.sat));
          crit_hits += want.prey_crit | want.pred_crit;
          sat_hits += want.sat;
        end
        steps_seen++;
        stall = draw_wait();
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready_i <= 0;
      end else begin
        m_axis_tready_i <= 1;
      end
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // populations: mostly moderate so that steps stay in range, sometimes extreme
  function automatic logic [31:0] any_pop();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return PopMax;
      2:       return $urandom_range(0, 32'h1_FFFF);
      3, 4:    return $urandom;
      default: return $urandom_range(32'h1_0000, 32'h0FFF_FFFF);
    endcase
  endfunction

  function automatic logic [31:0] any_rate();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return PopMax;
      2, 3:    return $urandom;
      4:       return $urandom_range(0, 32'h0000_FFFF);
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t it;
    it.prey = any_pop();
    it.pred = any_pop();
    it.birth = any_rate();
    it.predation = any_rate();
    it.capacity = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h1_0000) : any_pop();
    it.death = any_rate();
    it.attack = any_rate();
    it.conversion = any_rate();
    // references near the population land fractions around the threshold
    if ($urandom_range(0, 1)) begin
      it.prey_initial = it.prey + $urandom_range(0, it.prey >> 1) * 3;
      it.pred_initial = it.pred + $urandom_range(0, it.pred >> 1) * 3;
    end else begin
      it.prey_initial = any_pop();
      it.pred_initial = any_pop();
    end
    return it;
  endfunction

  task automatic write_regs(logic [DtW-1:0] dt, logic [CritW-1:0] crit);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_addr_i <= CfgIdxDt;
    cfg_wdata_i <= dt;
    step_dt = dt;
    @(posedge clk_i);
    cfg_addr_i <= CfgIdxCrit;
    cfg_wdata_i <= CfgDataW'(crit);
    crit_level = crit;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic wait_idle();
    wait (pending_pairs.size() == 0 && !s_axis_tvalid_i && expected_steps.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    pair_t it;
    logic [DtW-1:0] dts[8];
    logic [CritW-1:0] crits[8];
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_addr_i = CfgIdxDt;
    cfg_wdata_i = '0;
    step_dt = DtReset;
    crit_level = CritReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;

    // directed pairs at the reset settings
    pending_pairs.push_back('0);
    pending_pairs.push_back('1);
    it = '0;
    it.prey = 32'h0064_0000; it.pred = 32'h000A_0000;
    it.birth = 32'h0100_0000; it.predation = 32'h0001_0000;
    it.capacity = 32'h03E8_0000; it.death = 32'h0080_0000;
    it.attack = 32'h0002_0000; it.conversion = 32'h0080_0000;
    it.prey_initial = 32'h0064_0000; it.pred_initial = 32'h000A_0000;
    pending_pairs.push_back(it);
    // prey above capacity: logistic term turns negative
    it.capacity = 32'h0010_0000;
    pending_pairs.push_back(it);
    // capacity and references below one count as one
    it.capacity = 32'h0000_8000; it.prey_initial = 0; it.pred_initial = 32'h0000_FFFF;
    pending_pairs.push_back(it);
    // heavy predation drives prey below zero, huge death rate kills predators
    it.predation = PopMax; it.death = PopMax; it.pred = 32'h1000_0000;
    pending_pairs.push_back(it);
    // huge growth overflows both populations
    it = '1;
    it.capacity = PopMax; it.predation = 0; it.death = 0; it.prey = 32'h8000_0000;
    pending_pairs.push_back(it);
    // fractions crossing the threshold
    it = '0;
    it.prey = 32'h0001_0000; it.pred = 32'h0000_3333;
    it.prey_initial = 32'h0005_0000; it.pred_initial = 32'h0001_0000;
    pending_pairs.push_back(it);
    it.pred = 32'h0000_3332;
    pending_pairs.push_back(it);
    it.prey = 32'h00FF_FFFF; it.prey_initial = 32'h0001_0000;
    pending_pairs.push_back(it);

    // register settings per phase: reset, extremes, then random
    dts = '{DtReset, 24'd0, 24'hFF_FFFF, 24'd1, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0};
    crits = '{CritReset, 17'd0, 17'h1_0000, 17'h0_8000, 17'd0, 17'd0, 17'd0, 17'd0};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        wait_idle();
        if (ph >= 5) begin
          dts[ph] = DtW'($urandom_range(0, 24'hFF_FFFF));
          crits[ph] = CritW'($urandom_range(0, 17'h1_0000));
        end
        write_regs(dts[ph], crits[ph]);
      end
      no_idle = (ph == 3);
      for (int i = 0; i < 175; i++) pending_pairs.push_back(random_pair());
    end

    wait_idle();
    $display("%0d pairs sent, %0d results checked, %0d with a critical flag, %0d saturated",
             pairs_sent, steps_seen, crit_hits, sat_hits);
    $display("eight register settings covered, including zero and full-scale time steps");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ppes_pkg.sv
rtl/ppes_div.sv
rtl/predator_prey_euler_step_unit.sv
verif/testbench.sv
